// ===== rtl/core/mbrpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mbrpt_pkg;

  localparam int LOOP_W       = 7;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 128;

  localparam logic [8:0] OFF_ENTRIES = 9'h1be;
  localparam logic [8:0] OFF_SIG_END = 9'h1fe;
  localparam logic [8:0] OFF_SIG_LO  = 9'd510;
  localparam logic [8:0] OFF_SIG_HI  = 9'd511;
  localparam logic [7:0] SIG_LO_BYTE = 8'h55;
  localparam logic [7:0] SIG_HI_BYTE = 8'haa;
  localparam logic [7:0] TYPE_GPT    = 8'hee;
  localparam logic [7:0] MAX_SLICES_RST = 8'd64;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_FAIL  = 2'd2;

  localparam logic [1:0] KIND_SLICE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_BAD = 2'd1;
  localparam logic [1:0] STAT_GPT = 2'd2;

  typedef enum logic [2:0] {
    EM_REQ_TABLE,
    EM_REQ_LINK,
    EM_DONE,
    EM_PSLICE,
    EM_LSLICE
  } emit_sel_t;

  typedef struct packed {
    logic       start;
    logic       byte_wr;
    logic       sig_clear;
    logic       emit;
    emit_sel_t  sel;
    logic [1:0] status;
    logic [1:0] idx;
    logic       chain_sel;
    logic       link_from_entry;
    logic       loop_inc;
    logic       set_ext_flags;
  } dp_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       sig_now;
    logic       gpt;
    logic [3:0] ext_flags;
    logic [1:0] ent_nz;
    logic [1:0] ent_ext;
    logic       loop_ok;
    logic       full;
  } dp_stat_t;

  function automatic logic is_ext(input logic [7:0] t);
    return (t == 8'h05) || (t == 8'h0f) || (t == 8'h85);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mbrpt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mbrpt_dp #(
  parameter int LOOP_LIMIT = 100
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [7:0]                      cfg_wr_data,
  input  wire logic [47:0]                     table_lba,
  input  wire logic [7:0]                      data_byte,
  input  wire logic [8:0]                      byte_offset,
  input  wire mbrpt_pkg::dp_cmd_t              cmd,
  output mbrpt_pkg::dp_stat_t                  stat,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mbrpt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);
  import mbrpt_pkg::*;

  logic [7:0]        max_slices_r;
  logic [7:0]        ent_type_r  [4];
  logic [31:0]       ent_start_r [4];
  logic [31:0]       ent_size_r  [4];
  logic [31:0]       ext_start_r [4];
  logic [3:0]        ext_flags_r;
  logic              sig_lo_r;
  logic [31:0]       base_r;
  logic [32:0]       link_r;
  logic [LOOP_W-1:0] loop_r;
  logic [7:0]        slices_r;

  logic              out_valid_r;
  logic [1:0]        o_kind_r;
  logic [33:0]       o_start_r;
  logic [31:0]       o_size_r;
  logic [47:0]       o_lba_r;
  logic [7:0]        o_count_r;
  logic [1:0]        o_status_r;
  logic              o_last_r;

  logic [8:0] rel;
  logic [1:0] ent;
  logic [3:0] fld;
  logic       in_entries;

  assign rel        = byte_offset - OFF_ENTRIES;
  assign ent        = rel[5:4];
  assign fld        = rel[3:0];
  assign in_entries = (byte_offset >= OFF_ENTRIES) && (byte_offset < OFF_SIG_END);

  always_comb begin
    stat.out_free  = !out_valid_r || out_tready;
    stat.sig_now   = sig_lo_r && (data_byte == SIG_HI_BYTE);
    stat.gpt       = (ent_type_r[0] == TYPE_GPT) || (ent_type_r[1] == TYPE_GPT) ||
                     (ent_type_r[2] == TYPE_GPT) || (ent_type_r[3] == TYPE_GPT);
    stat.ext_flags = ext_flags_r;
    stat.ent_nz    = {ent_size_r[1] != 32'd0, ent_size_r[0] != 32'd0};
    stat.ent_ext   = {is_ext(ent_type_r[1]), is_ext(ent_type_r[0])};
    stat.loop_ok   = loop_r < LOOP_W'(LOOP_LIMIT);
    stat.full      = slices_r >= max_slices_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slices_r <= MAX_SLICES_RST;
      for (int i = 0; i < 4; i++) begin
        ent_type_r[i]  <= '0;
        ent_start_r[i] <= '0;
        ent_size_r[i]  <= '0;
      end
      ext_flags_r <= '0;
      sig_lo_r    <= 1'b0;
      base_r      <= '0;
      link_r      <= '0;
      loop_r      <= '0;
      slices_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) max_slices_r <= cfg_wr_data;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      if (cmd.start) begin
        ext_flags_r <= '0;
        loop_r      <= '0;
        slices_r    <= '0;
        sig_lo_r    <= 1'b0;
      end

      if (cmd.byte_wr) begin
        if (in_entries) begin
          if (fld == 4'd4) begin
            ent_type_r[ent] <= data_byte;
          end else if (fld[3:2] == 2'b10) begin
            ent_start_r[ent][8*fld[1:0] +: 8] <= data_byte;
          end else if (fld[3:2] == 2'b11) begin
            ent_size_r[ent][8*fld[1:0] +: 8] <= data_byte;
          end
        end else if (byte_offset == OFF_SIG_LO) begin
          sig_lo_r <= (data_byte == SIG_LO_BYTE);
        end
      end
      if (cmd.sig_clear) sig_lo_r <= 1'b0;

      if (cmd.set_ext_flags) begin
        for (int i = 0; i < 4; i++) begin
          ext_flags_r[i] <= is_ext(ent_type_r[i]);
          if (is_ext(ent_type_r[i])) ext_start_r[i] <= ent_start_r[i];
        end
      end

      if (cmd.chain_sel) begin
        base_r <= ext_start_r[cmd.idx];
        link_r <= {1'b0, ext_start_r[cmd.idx]};
        loop_r <= '0;
      end
      if (cmd.link_from_entry) link_r <= {1'b0, base_r} + {1'b0, ent_start_r[cmd.idx]};
      if (cmd.loop_inc) loop_r <= loop_r + 1'b1;

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        o_start_r   <= '0;
        o_size_r    <= '0;
        o_lba_r     <= '0;
        o_count_r   <= '0;
        o_status_r  <= STAT_OK;
        unique case (cmd.sel)
          EM_REQ_TABLE: begin
            o_kind_r <= KIND_READ;
            o_lba_r  <= table_lba;
            o_last_r <= 1'b1;
          end
          EM_REQ_LINK: begin
            o_kind_r <= KIND_READ;
            o_lba_r  <= {15'd0, link_r};
            o_last_r <= 1'b1;
          end
          EM_DONE: begin
            o_kind_r   <= KIND_DONE;
            o_count_r  <= slices_r;
            o_status_r <= cmd.status;
            o_last_r   <= 1'b1;
          end
          EM_PSLICE: begin
            o_kind_r  <= KIND_SLICE;
            o_start_r <= {2'b00, ent_start_r[cmd.idx]};
            o_size_r  <= ent_size_r[cmd.idx];
            o_last_r  <= 1'b0;
            slices_r  <= slices_r + 1'b1;
          end
          EM_LSLICE: begin
            o_kind_r  <= KIND_SLICE;
            o_start_r <= {1'b0, link_r} + {2'b00, ent_start_r[cmd.idx]};
            o_size_r  <= ent_size_r[cmd.idx];
            o_last_r  <= 1'b0;
            slices_r  <= slices_r + 1'b1;
            loop_r    <= '0;
          end
          default: o_kind_r <= KIND_DONE;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'd0, o_status_r, o_count_r, o_lba_r, o_size_r, o_start_r};

endmodule
`default_nettype wire

// ===== rtl/core/mbrpt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mbrpt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [1:0]          req_type,
  input  wire logic [8:0]          byte_offset,
  input  wire mbrpt_pkg::dp_stat_t stat,
  output mbrpt_pkg::dp_cmd_t       cmd
);
  import mbrpt_pkg::*;

  typedef enum logic [2:0] {
    S_IN, S_EPRI, S_PSL, S_WALK, S_ELINK, S_LSL, S_LNEXT
  } state_t;

  typedef enum logic [1:0] {PH_IDLE, PH_PRI, PH_CHAIN} phase_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] i_r, i_nxt;
  logic [1:0] chain_r, chain_nxt;
  logic       have_r, have_nxt;
  logic       sig_r, sig_nxt;

  logic       found;
  logic [1:0] found_idx;
  logic [2:0] next_chain;
  logic       acc;

  assign next_chain = {1'b0, chain_r} + 3'd1;
  assign in_tready  = (state_r == S_IN) && stat.out_free;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = 3; k >= 0; k--) begin
      if (stat.ext_flags[k] && (3'(k) >= i_r)) begin
        found     = 1'b1;
        found_idx = 2'(k);
      end
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = EM_DONE;
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    chain_nxt = chain_r;
    have_nxt  = have_r;
    sig_nxt   = sig_r;
    unique case (state_r)
      S_IN: begin
        if (acc) begin
          if (req_type == REQ_START) begin
            cmd.start = 1'b1;
            cmd.emit  = 1'b1;
            cmd.sel   = EM_REQ_TABLE;
            phase_nxt = PH_PRI;
            chain_nxt = '0;
          end else if (req_type == REQ_BYTE && phase_r != PH_IDLE) begin
            cmd.byte_wr = 1'b1;
            if (byte_offset == OFF_SIG_HI) begin
              cmd.sig_clear = 1'b1;
              sig_nxt       = stat.sig_now;
              i_nxt         = '0;
              state_nxt     = (phase_r == PH_PRI) ? S_EPRI : S_ELINK;
            end
          end else if (req_type == REQ_FAIL && phase_r != PH_IDLE) begin
            cmd.sig_clear = 1'b1;
            if (phase_r == PH_PRI) begin
              cmd.emit   = 1'b1;
              cmd.sel    = EM_DONE;
              cmd.status = STAT_BAD;
              phase_nxt  = PH_IDLE;
            end else begin
              i_nxt     = next_chain;
              have_nxt  = 1'b0;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_EPRI: begin
        if (!sig_r || stat.gpt) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.sel    = EM_DONE;
            cmd.status = !sig_r ? STAT_BAD : STAT_GPT;
            phase_nxt  = PH_IDLE;
            state_nxt  = S_IN;
          end
        end else begin
          state_nxt = S_PSL;
        end
      end
      S_PSL: begin
        if (!i_r[2] && !stat.full) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.sel  = EM_PSLICE;
            cmd.idx  = i_r[1:0];
            i_nxt    = i_r + 3'd1;
          end
        end else begin
          cmd.set_ext_flags = 1'b1;
          i_nxt     = '0;
          have_nxt  = 1'b0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (have_r && stat.loop_ok) begin
          if (stat.out_free) begin
            cmd.emit     = 1'b1;
            cmd.sel      = EM_REQ_LINK;
            cmd.loop_inc = 1'b1;
            phase_nxt    = PH_CHAIN;
            state_nxt    = S_IN;
          end
        end else if (!found) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.sel    = EM_DONE;
            cmd.status = STAT_OK;
            phase_nxt  = PH_IDLE;
            state_nxt  = S_IN;
          end
        end else begin
          // load the chain of the next extended primary entry
          cmd.chain_sel = 1'b1;
          cmd.idx       = found_idx;
          chain_nxt     = found_idx;
          i_nxt         = {1'b0, found_idx} + 3'd1;
          have_nxt      = 1'b1;
        end
      end
      S_ELINK: begin
        if (!sig_r) begin
          i_nxt     = next_chain;
          have_nxt  = 1'b0;
          state_nxt = S_WALK;
        end else begin
          i_nxt     = '0;
          state_nxt = S_LSL;
        end
      end
      S_LSL: begin
        if (i_r[1]) begin
          state_nxt = S_LNEXT;
        end else if (stat.ent_nz[i_r[0]] && !stat.ent_ext[i_r[0]]) begin
          if (stat.full) begin
            i_nxt     = next_chain;
            have_nxt  = 1'b0;
            state_nxt = S_WALK;
          end else if (stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.sel  = EM_LSLICE;
            cmd.idx  = {1'b0, i_r[0]};
            i_nxt    = i_r + 3'd1;
          end
        end else begin
          i_nxt = i_r + 3'd1;
        end
      end
      S_LNEXT: begin
        i_nxt     = next_chain;
        state_nxt = S_WALK;
        have_nxt  = 1'b0;
        if (stat.ent_nz[0] && stat.ent_ext[0]) begin
          cmd.link_from_entry = 1'b1;
          cmd.idx             = 2'd0;
          have_nxt            = 1'b1;
        end else if (stat.ent_nz[1] && stat.ent_ext[1]) begin
          cmd.link_from_entry = 1'b1;
          cmd.idx             = 2'd1;
          have_nxt            = 1'b1;
        end
      end
      default: state_nxt = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      phase_r <= PH_IDLE;
      i_r     <= '0;
      chain_r <= '0;
      have_r  <= 1'b0;
      sig_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      chain_r <= chain_nxt;
      have_r  <= have_nxt;
      sig_r   <= sig_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mbr_partition_table_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake           Payload
// in       slave      in_tvalid/tready    tuser req_type; tdata lba, byte, offset
// out      master     out_tvalid/tready   tuser result_kind; tlast last; tdata slice
// cfg      write      cfg_wr_en           cfg_wr_data = max_slices
//
// Sector bytes, start items and ignored items are taken one per cycle while the
// output is free. A read failure on the table sector is answered at its own edge;
// one on a link holds the input while the chain walk goes on. Byte 511 holds it,
// one result at most per cycle from the output register, before the next is taken.
// Synchronous active-low reset; max_slices resets to 64.
// A stalled output holds the controller and blocks input.
module mbr_partition_table_parser_core #(
  parameter int LOOP_LIMIT = 100
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [47:0] table_lba, [55:48] data_byte, [64:56] byte_offset
  input  wire logic [mbrpt_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [33:0] slice_start, [65:34] slice_size, [113:66] read_lba,
  // [121:114] slice_count, [123:122] status
  output logic [mbrpt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [1:0] result_kind
  output logic [1:0]                            out_tuser,
  output logic                                  out_tlast,
  input  wire logic                             cfg_wr_en,
  input  wire logic [7:0]                       cfg_wr_data
);
  import mbrpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mbrpt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .req_type    (in_tuser),
    .byte_offset (in_tdata[64:56]),
    .stat        (stat),
    .cmd         (cmd)
  );

  mbrpt_dp #(
    .LOOP_LIMIT (LOOP_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .table_lba   (in_tdata[47:0]),
    .data_byte   (in_tdata[55:48]),
    .byte_offset (in_tdata[64:56]),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import mbrpt_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic [47:0] lba;
    logic [7:0]  data;
    logic [8:0]  off;
  } sector_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [33:0] start;
    logic [31:0] size;
    logic [47:0] lba;
    logic [7:0]  count;
    logic [1:0]  status;
    logic        last;
  } parse_result_t;

  localparam int LOOP_LIMIT = 100;
  localparam logic [1:0] REQ_JUNK = 2'd3;
  localparam logic [1:0] PH_IDLE = 2'd0, PH_PRIMARY = 2'd1, PH_CHAIN = 2'd2;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast, cfg_wr_en;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser, out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [7:0]             cfg_wr_data;

  mbr_partition_table_parser_core #(
    .LOOP_LIMIT(LOOP_LIMIT)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  sector_item_t  pending_items[$];
  parse_result_t expected_results[$];
  int            errors = 0;
  bit            no_idle = 0;
  bit            hold_go = 0;
  int            hold_left = 400;

  // parser state as the block should hold it
  logic [7:0]  m_max_slices;
  logic [1:0]  m_phase;
  logic [7:0]  m_type[4];
  logic [31:0] m_start[4];
  logic [31:0] m_size[4];
  logic [1:0]  m_sig;
  logic [3:0]  m_ext_flags;
  logic [31:0] m_ext_start[4];
  logic [1:0]  m_chain_idx;
  logic [31:0] m_chain_base;
  logic [32:0] m_link;
  logic [6:0]  m_loops;
  logic [7:0]  m_found;

  function automatic bit is_ext_type(logic [7:0] t);
    return t == 8'h05 || t == 8'h0f || t == 8'h85;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [33:0] start, logic [31:0] size,
                                      logic [47:0] lba, logic [7:0] count, logic [1:0] status);
    parse_result_t r;
    r = '{kind, start, size, lba, count, status, 1'b0};
    expected_results.push_back(r);
  endfunction

  // request the next link, else move on to the next extended primary entry or finish
  function automatic void walk_chain(int i, bit have_link);
    while (1) begin
      if (have_link && m_loops < LOOP_LIMIT) begin
        m_loops++;
        m_phase = PH_CHAIN;
        push_result(KIND_READ, '0, '0, {15'd0, m_link}, '0, STAT_OK);
        return;
      end
      while (i < 4 && !m_ext_flags[i]) i++;
      if (i >= 4) begin
        m_phase = PH_IDLE;
        push_result(KIND_DONE, '0, '0, '0, m_found, STAT_OK);
        return;
      end
      m_chain_idx = i[1:0];
      m_chain_base = m_ext_start[i];
      m_link = {1'b0, m_chain_base};
      m_loops = 0;
      have_link = 1;
      i++;
    end
  endfunction

  function automatic void finish_table(bit sig);
    if (!sig) begin
      m_phase = PH_IDLE;
      push_result(KIND_DONE, '0, '0, '0, '0, STAT_BAD);
      return;
    end
    for (int i = 0; i < 4; i++)
      if (m_type[i] == TYPE_GPT) begin
        m_phase = PH_IDLE;
        push_result(KIND_DONE, '0, '0, '0, '0, STAT_GPT);
        return;
      end
    for (int i = 0; i < 4 && m_found < m_max_slices; i++) begin
      push_result(KIND_SLICE, {2'b0, m_start[i]}, m_size[i], '0, '0, STAT_OK);
      m_found++;
    end
    m_ext_flags = '0;
    for (int i = 0; i < 4; i++)
      if (is_ext_type(m_type[i])) begin
        m_ext_flags[i] = 1'b1;
        m_ext_start[i] = m_start[i];
      end
    walk_chain(0, 0);
  endfunction

  function automatic void finish_link(bit sig);
    int nxt;
    nxt = int'(m_chain_idx) + 1;
    if (!sig) begin
      walk_chain(nxt, 0);
      return;
    end
    for (int i = 0; i < 2; i++) begin
      if (m_size[i] == 0 || is_ext_type(m_type[i])) continue;
      if (m_found >= m_max_slices) begin
        walk_chain(nxt, 0);
        return;
      end
      push_result(KIND_SLICE, {1'b0, m_link} + {2'b0, m_start[i]}, m_size[i], '0, '0, STAT_OK);
      m_found++;
      m_loops = 0;
    end
    for (int i = 0; i < 2; i++)
      if (m_size[i] != 0 && is_ext_type(m_type[i])) begin
        m_link = {1'b0, m_chain_base} + {1'b0, m_start[i]};
        walk_chain(nxt, 1);
        return;
      end
    walk_chain(nxt, 0);
  endfunction

  function automatic void predict_item(sector_item_t it);
    int n_before;
    logic [8:0] rel;
    int e, f;
    bit sig;
    n_before = expected_results.size();
    if (it.req == REQ_START) begin
      m_phase = PH_PRIMARY;
      m_sig = '0;
      m_ext_flags = '0;
      m_chain_idx = '0;
      m_loops = '0;
      m_found = '0;
      push_result(KIND_READ, '0, '0, it.lba, '0, STAT_OK);
    end else if (it.req == REQ_FAIL && m_phase != PH_IDLE) begin
      if (m_phase == PH_PRIMARY) begin
        m_phase = PH_IDLE;
        push_result(KIND_DONE, '0, '0, '0, '0, STAT_BAD);
      end else begin
        walk_chain(int'(m_chain_idx) + 1, 0);
      end
      m_sig = '0;
    end else if (it.req == REQ_BYTE && m_phase != PH_IDLE) begin
      if (it.off >= OFF_ENTRIES && it.off < OFF_SIG_END) begin
        rel = it.off - OFF_ENTRIES;
        e = rel[5:4];
        f = rel[3:0];
        if (f == 4) m_type[e] = it.data;
        else if (f >= 8 && f < 12) m_start[e][(f-8)*8 +: 8] = it.data;
        else if (f >= 12) m_size[e][(f-12)*8 +: 8] = it.data;
      end else if (it.off == OFF_SIG_LO) begin
        m_sig[0] = (it.data == SIG_LO_BYTE);
      end else if (it.off == OFF_SIG_HI) begin
        m_sig[1] = (it.data == SIG_HI_BYTE);
        sig = (m_sig == 2'b11);
        m_sig = '0;
        if (m_phase == PH_PRIMARY) finish_table(sig);
        else finish_link(sig);
      end
    end
    if (expected_results.size() > n_before)
      expected_results[expected_results.size()-1].last = 1'b1;
  endfunction

  // stimulus builders
  task automatic q_item(logic [1:0] req, logic [47:0] lba, logic [7:0] data, logic [8:0] off);
    sector_item_t it;
    it = '{req, lba, data, off};
    pending_items.push_back(it);
  endtask

  task automatic q_start(logic [47:0] lba);
    q_item(REQ_START, lba, 8'($urandom), 9'($urandom));
  endtask

  task automatic q_fail();
    q_item(REQ_FAIL, {$urandom, $urandom}, 8'($urandom), 9'($urandom));
  endtask

  task automatic q_byte(logic [8:0] off, logic [7:0] data);
    q_item(REQ_BYTE, {$urandom, $urandom}, data, off);
  endtask

  task automatic q_entry(int e, logic [7:0] t, logic [31:0] s, logic [31:0] z);
    logic [8:0] base;
    base = OFF_ENTRIES + 9'(e * 16);
    q_byte(base + 9'd4, t);
    for (int k = 0; k < 4; k++) q_byte(base + 9'(8 + k), s[k*8 +: 8]);
    for (int k = 0; k < 4; k++) q_byte(base + 9'(12 + k), z[k*8 +: 8]);
  endtask

  task automatic q_sig(bit good);
    logic [7:0] lo, hi;
    lo = SIG_LO_BYTE;
    hi = SIG_HI_BYTE;
    if (!good) begin
      if ($urandom_range(0, 1)) lo = 8'($urandom);
      else hi = hi ^ 8'(1 << $urandom_range(0, 7));
    end
    if (good || $urandom_range(0, 3) != 0) q_byte(OFF_SIG_LO, lo);
    q_byte(OFF_SIG_HI, hi);
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h05;
      2: return 8'h0f;
      3: return 8'h85;
      4: return 8'h83;
      5: return 8'($urandom);
      6: return ($urandom_range(0, 5) == 0) ? TYPE_GPT : 8'h0c;
      default: return 8'h07;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic q_random_parse();
    int links;
    if ($urandom_range(0, 9) == 0) q_item(REQ_JUNK, {$urandom, $urandom}, 8'($urandom), 9'($urandom));
    q_start({$urandom, $urandom});
    repeat ($urandom_range(0, 3)) q_byte(9'($urandom_range(0, 445)), 8'($urandom));
    for (int e = 0; e < 4; e++) q_entry(e, pick_type(), $urandom, pick_size());
    if ($urandom_range(0, 11) == 0) q_fail();
    else q_sig($urandom_range(0, 9) != 0);
    links = $urandom_range(0, 1);
    for (int l = 0; l < links; l++) begin
      if ($urandom_range(0, 11) == 0) begin
        q_fail();
        continue;
      end
      q_entry(0, ($urandom_range(0, 4) == 0) ? pick_type() : 8'h83,
              $urandom_range(0, 255), pick_size());
      q_entry(1, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'h05, $urandom, pick_size());
      q_sig($urandom_range(0, 9) != 0);
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_max_slices(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    m_max_slices = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver
  sector_item_t cur_item;
  int           in_gap = 0;
  always @(posedge clk) begin
    bit nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_item(cur_item);
      nv = in_tvalid && !in_tready;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          nv = 1'b1;
          in_gap = pick_gap();
          in_tdata <= {7'd0, cur_item.off, cur_item.data, cur_item.lba};
          in_tuser <= cur_item.req;
        end
      end
      in_tvalid <= nv;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk)
    if (hold_go && hold_left > 0) hold_left <= hold_left - 1;

  // result monitor
  int out_gap = 0;
  always @(posedge clk) begin
    parse_result_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result kind", 48'(out_tuser), '0);
        end else begin
          w = expected_results.pop_front();
          if (out_tuser != w.kind) report_mismatch("result_kind", 48'(out_tuser), 48'(w.kind));
          if (out_tdata[33:0] != w.start)
            report_mismatch("slice_start", 48'(out_tdata[33:0]), 48'(w.start));
          if (out_tdata[65:34] != w.size)
            report_mismatch("slice_size", 48'(out_tdata[65:34]), 48'(w.size));
          if (out_tdata[113:66] != w.lba) report_mismatch("read_lba", out_tdata[113:66], w.lba);
          if (out_tdata[121:114] != w.count)
            report_mismatch("slice_count", 48'(out_tdata[121:114]), 48'(w.count));
          if (out_tdata[123:122] != w.status)
            report_mismatch("status", 48'(out_tdata[123:122]), 48'(w.status));
          if (out_tlast != w.last) report_mismatch("last", 48'(out_tlast), 48'(w.last));
        end
      end
      if (hold_go && hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_gap = pick_gap();
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("** mbr_partition_table_parser_core: FAILED **");
    $finish;
  end

  initial begin
    logic [7:0] settings[3];
    settings = '{8'd3, 8'd0, 8'd1};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_BYTE;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    m_max_slices = MAX_SLICES_RST;
    m_phase = PH_IDLE;
    m_sig = '0;
    m_ext_flags = '0;
    m_chain_idx = '0;
    m_chain_base = '0;
    m_link = '0;
    m_loops = '0;
    m_found = '0;
    for (int i = 0; i < 4; i++) begin
      m_type[i] = '0;
      m_start[i] = '0;
      m_size[i] = '0;
      m_ext_start[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // idle noise is dropped
    q_byte(OFF_SIG_HI, SIG_HI_BYTE);
    q_fail();
    q_item(REQ_JUNK, '1, 8'hff, 9'h1ff);
    // GPT protective entry
    q_start('1);
    q_entry(2, TYPE_GPT, 32'hffff_ffff, 32'hffff_ffff);
    q_sig(1);
    // bad signature, then read failure on the table sector
    q_start('0);
    q_sig(0);
    q_start(48'h1234_5678_9abc);
    q_fail();
    // start while busy, extended chain with extreme sums, then a link failure
    q_start(48'h8000_0000_0000);
    q_byte(9'd0, 8'hff);
    q_start(48'd63);
    q_entry(0, 8'h83, 32'hffff_ffff, 32'hffff_ffff);
    q_entry(1, 8'h0f, 32'hffff_fff0, 32'd100);
    q_entry(2, 8'h00, 32'd0, 32'd0);
    q_entry(3, 8'h85, 32'd2048, 32'd10);
    q_sig(1);
    q_entry(0, 8'h07, 32'hffff_ffff, 32'hffff_ffff);
    q_entry(1, 8'h05, 32'h20, 32'd1);
    q_sig(1);
    q_fail();
    // second chain: a link that only points on, then the loop guard
    q_entry(0, 8'h00, 32'd0, 32'd0);
    q_entry(1, 8'h05, 32'd0, 32'd1);
    q_sig(1);
    repeat (LOOP_LIMIT + 2) q_sig(1);
    wait_idle();

    foreach (settings[p]) begin
      write_max_slices(settings[p]);
      no_idle = (p == 1);
      if (p == 2) begin
        @(negedge clk);
        hold_go = 1;
      end
      q_random_parse();
      wait_idle();
    end

    if (errors == 0)
      $display("** mbr_partition_table_parser_core: PASSED **");
    else
      $display("** mbr_partition_table_parser_core: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/mbrpt_pkg.sv
rtl/core/mbrpt_dp.sv
rtl/core/mbrpt_ctrl.sv
rtl/core/mbr_partition_table_parser_core.sv
dv/tb_top.sv
